// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the shadow checker RTL.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define SMAC_ASSERT(name, clk_i, rstn_i, prop, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
        else $error(msg);

// Condition must never be true outside reset
`define SMAC_ASSERT_NEVER(name, clk_i, rstn_i, cond, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
        else $error(msg);

`else

`define SMAC_ASSERT(name, clk_i, rstn_i, prop, msg)
`define SMAC_ASSERT_NEVER(name, clk_i, rstn_i, cond, msg)

`endif

`endif

// ===== hw/rtl/smac_pkg.sv =====
// Constants, action codes and shadow memory request types of the shadow checker.
// No dependencies; imported by smac_shadow and shadow_memory_access_checker.
package smac_pkg;

    // Heap geometry: one shadow byte per 8-byte granule
    localparam int HEAP_BYTES  = 1048576;
    localparam int ENTRY_COUNT = HEAP_BYTES / 8;
    localparam int ENTRY_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int OFF_W       = ENTRY_W + 3;

    // Item field widths
    localparam int ADDR_W = 64;
    localparam int BASE_W = 48;
    localparam int LEN_W  = 21;
    localparam int CODE_W = 8;
    localparam int BAD_W  = 17;

    // Offset plus length, and its granule index
    localparam int SUM_W = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;
    localparam int TE_W  = SUM_W - 3;

    localparam logic [ADDR_W-1:0]  SPAN_BYTES     = ADDR_W'(ENTRY_COUNT) << 3;
    localparam logic [TE_W-1:0]    ENTRY_COUNT_TE = TE_W'(ENTRY_COUNT);
    localparam logic [ENTRY_W-1:0] LAST_ENTRY     = ENTRY_W'(ENTRY_COUNT - 1);

    localparam logic [CODE_W-1:0] POISON_RESET = 8'hFE;
    localparam logic [2:0]        GRANULE_MASK = 3'b111;

    typedef enum logic [1:0] {
        ACT_CHECK    = 2'd0,
        ACT_POISON   = 2'd1,
        ACT_UNPOISON = 2'd2
    } action_t;

    // Shadow memory write request
    typedef struct packed {
        logic               we;
        logic [ENTRY_W-1:0] addr;
        logic [CODE_W-1:0]  data;
    } shadow_wr_t;

    // Shadow memory read request
    typedef struct packed {
        logic               re;
        logic [ENTRY_W-1:0] addr;
    } shadow_rd_t;

endpackage

// ===== hw/rtl/shadow_memory_access_checker.sv =====
// Shadow memory access checker: one result item per input item, one item at a time.
// Check: decode, setup, scan to the first nonzero entry or the end, result.
// Poison/unpoison: decode, setup, fill through the single write port of the shadow memory,
// a tail write for a partial unpoison tail, result. Outside the heap: decode, result.
// Result stalls hold the result state. After reset a sweep writes 0xFE to all 131072
// entries, item_stall high. Depends on smac_pkg, smac_shadow and assert_macros.svh.
`include "assert_macros.svh"

module shadow_memory_access_checker import smac_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_write,
    input  logic [BASE_W-1:0] cfg_data,
    // item channel
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        action,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  length,
    input  logic [CODE_W-1:0] poison_code,
    input  logic              is_write,
    // result channel
    output logic              result_valid,
    input  logic              result_stall,
    output logic              fault,
    output logic              fault_is_write,
    output logic [BAD_W-1:0]  bad_entry
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SETUP,
        ST_FILL,
        ST_TAIL,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t             state_reg;
    logic [BASE_W-1:0]  base_reg;

    // captured item
    action_t            act_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [CODE_W-1:0]  code_reg;
    logic               wr_reg;

    // walk state
    logic [OFF_W-1:0]   off_reg;
    logic [ENTRY_W-1:0] idx_reg;
    logic [ENTRY_W-1:0] end_reg;
    logic [CODE_W-1:0]  val_reg;
    logic               tail_pend_reg;
    logic [ENTRY_W-1:0] tail_addr_reg;
    logic [2:0]         tail_val_reg;
    logic               past_reg;
    logic [2:0]         last_off_reg;
    logic               res_fault_reg;
    logic [ENTRY_W-1:0] res_hit_reg;

    // result register
    logic               result_valid_reg;
    logic               fault_reg;
    logic               fault_is_write_reg;
    logic [BAD_W-1:0]   bad_entry_reg;

    shadow_wr_t         wr;
    shadow_rd_t         rd;
    logic [CODE_W-1:0]  rd_data;
    logic               clr_busy;

    logic               item_accept;
    logic               result_take;
    logic               result_load;

    // decode stage signals
    logic [ADDR_W-1:0]  base_ext;
    logic [ADDR_W-1:0]  diff;
    logic               below_base;
    logic               in_heap;

    // setup stage signals
    logic [ENTRY_W-1:0] first_e;
    logic [SUM_W-1:0]   tail_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [TE_W-1:0]    tail_e;
    logic [TE_W-1:0]    tail_dec;
    logic [TE_W-1:0]    last_e;
    logic               tail_in;
    logic               past;
    logic               fill_empty;
    logic               tail_need;
    logic [ENTRY_W-1:0] fill_last;
    logic [ENTRY_W-1:0] scan_to;

    // scan stage signals
    logic               scan_hit;
    logic               scan_end;
    logic               scan_legal;

    smac_shadow u_shadow (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data),
        .busy    (clr_busy)
    );

    assign item_stall  = (state_reg != ST_IDLE) || clr_busy;
    assign item_accept = item_valid && !item_stall;
    assign result_take = result_valid_reg && !result_stall;
    // in ST_RESULT, the result register loads when it is empty or being emptied
    assign result_load = (state_reg == ST_RESULT) && (!result_valid_reg || !result_stall);

    // Heap membership: one wide subtract with borrow, then a bound compare
    always_comb
    begin
        base_ext           = {{(ADDR_W-BASE_W){1'b0}}, base_reg[BASE_W-1:3], 3'b000};
        {below_base, diff} = {1'b0, addr_reg} - {1'b0, base_ext};
        in_heap            = !below_base && (diff < SPAN_BYTES);
    end

    // Range bounds in granules
    always_comb
    begin
        first_e    = off_reg[OFF_W-1:3];
        tail_sum   = SUM_W'(off_reg) + SUM_W'(len_reg);
        last_sum   = tail_sum - SUM_W'(1);
        tail_e     = tail_sum[SUM_W-1:3];
        last_e     = last_sum[SUM_W-1:3];
        tail_dec   = tail_e - TE_W'(1);
        tail_in    = tail_e < ENTRY_COUNT_TE;
        past       = !(last_e < ENTRY_COUNT_TE);
        fill_empty = tail_e == {{(TE_W-ENTRY_W){1'b0}}, first_e};
        tail_need  = (act_reg == ACT_UNPOISON) && ((len_reg[2:0] & GRANULE_MASK) != 3'd0)
                     && tail_in;
        fill_last  = tail_in ? tail_dec[ENTRY_W-1:0] : LAST_ENTRY;
        scan_to    = past ? LAST_ENTRY : last_e[ENTRY_W-1:0];
    end

    // First nonzero entry, and whether it covers the last byte legally
    always_comb
    begin
        scan_hit   = rd_data != '0;
        scan_end   = idx_reg == end_reg;
        scan_legal = !past_reg && scan_end
                     && ($signed({5'b00000, last_off_reg}) < $signed(rd_data));
    end

    // Shadow memory requests
    always_comb
    begin
        wr = '0;
        rd = '0;
        case (state_reg)
            ST_FILL:
            begin
                wr.we   = 1'b1;
                wr.addr = idx_reg;
                wr.data = val_reg;
            end
            ST_TAIL:
            begin
                wr.we   = 1'b1;
                wr.addr = tail_addr_reg;
                wr.data = {{(CODE_W-3){1'b0}}, tail_val_reg};
            end
            ST_SETUP:
            begin
                rd.re   = (act_reg == ACT_CHECK) && (len_reg != '0);
                rd.addr = first_e;
            end
            ST_SCAN:
            begin
                rd.re   = !scan_hit && !scan_end;
                rd.addr = idx_reg + ENTRY_W'(1);
            end
            default:
            begin
                wr = '0;
                rd = '0;
            end
        endcase
    end

    // Heap base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_write)
        begin
            base_reg <= cfg_data;
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            act_reg            <= ACT_CHECK;
            addr_reg           <= '0;
            len_reg            <= '0;
            code_reg           <= '0;
            wr_reg             <= 1'b0;
            off_reg            <= '0;
            idx_reg            <= '0;
            end_reg            <= '0;
            val_reg            <= '0;
            tail_pend_reg      <= 1'b0;
            tail_addr_reg      <= '0;
            tail_val_reg       <= '0;
            past_reg           <= 1'b0;
            last_off_reg       <= '0;
            res_fault_reg      <= 1'b0;
            res_hit_reg        <= '0;
            result_valid_reg   <= 1'b0;
            fault_reg          <= 1'b0;
            fault_is_write_reg <= 1'b0;
            bad_entry_reg      <= '0;
        end
        else
        begin
            if (result_take && !result_load)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        act_reg   <= action_t'(action);
                        addr_reg  <= address;
                        len_reg   <= length;
                        code_reg  <= poison_code;
                        wr_reg    <= is_write;
                        state_reg <= ST_DECODE;
                    end
                end

                ST_DECODE:
                begin
                    res_fault_reg <= 1'b0;
                    res_hit_reg   <= '0;
                    off_reg       <= diff[OFF_W-1:0];
                    state_reg     <= in_heap ? ST_SETUP : ST_RESULT;
                end

                ST_SETUP:
                begin
                    case (act_reg)
                        ACT_POISON, ACT_UNPOISON:
                        begin
                            idx_reg       <= first_e;
                            end_reg       <= fill_last;
                            val_reg       <= (act_reg == ACT_POISON) ? code_reg : '0;
                            tail_pend_reg <= tail_need;
                            tail_addr_reg <= tail_e[ENTRY_W-1:0];
                            tail_val_reg  <= len_reg[2:0] & GRANULE_MASK;
                            if (!fill_empty)
                            begin
                                state_reg <= ST_FILL;
                            end
                            else if (tail_need)
                            begin
                                state_reg <= ST_TAIL;
                            end
                            else
                            begin
                                state_reg <= ST_RESULT;
                            end
                        end
                        ACT_CHECK:
                        begin
                            idx_reg      <= first_e;
                            end_reg      <= scan_to;
                            past_reg     <= past;
                            last_off_reg <= last_sum[2:0] & GRANULE_MASK;
                            state_reg    <= (len_reg == '0) ? ST_RESULT : ST_SCAN;
                        end
                        default:
                        begin
                            state_reg <= ST_RESULT;
                        end
                    endcase
                end

                // One entry written per cycle
                ST_FILL:
                begin
                    if (idx_reg == end_reg)
                    begin
                        state_reg <= tail_pend_reg ? ST_TAIL : ST_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ENTRY_W'(1);
                    end
                end

                ST_TAIL:
                begin
                    state_reg <= ST_RESULT;
                end

                // One entry examined per cycle; next read already issued
                ST_SCAN:
                begin
                    if (scan_hit)
                    begin
                        res_fault_reg <= past_reg || !scan_legal;
                        res_hit_reg   <= idx_reg;
                        state_reg     <= ST_RESULT;
                    end
                    else if (scan_end)
                    begin
                        res_fault_reg <= past_reg;
                        res_hit_reg   <= past_reg ? LAST_ENTRY : '0;
                        state_reg     <= ST_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ENTRY_W'(1);
                    end
                end

                // Hand the result over once the output register is free
                ST_RESULT:
                begin
                    if (result_load)
                    begin
                        result_valid_reg   <= 1'b1;
                        fault_reg          <= res_fault_reg;
                        fault_is_write_reg <= res_fault_reg && wr_reg;
                        bad_entry_reg      <= BAD_W'(res_hit_reg);
                        state_reg          <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign fault          = fault_reg;
    assign fault_is_write = fault_is_write_reg;
    assign bad_entry      = bad_entry_reg;

    `SMAC_ASSERT(a_stall_in_sweep, clk, rst_n,
        clr_busy |-> item_stall, "item taken during shadow sweep")
    `SMAC_ASSERT(a_accept_decodes, clk, rst_n,
        item_accept |=> (state_reg == ST_DECODE), "accepted item not decoded")
    `SMAC_ASSERT_NEVER(a_no_write_in_scan, clk, rst_n,
        (state_reg == ST_SCAN) && wr.we, "shadow write during scan")
    `SMAC_ASSERT(a_result_from_seq, clk, rst_n,
        $rose(result_valid_reg) |-> $past(state_reg == ST_RESULT), "stray result")

endmodule

// ===== hw/rtl/smac_shadow.sv =====
// Shadow byte memory with its post-reset fill sweep to the poison value.
// Depends on smac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smac_shadow import smac_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  shadow_wr_t        wr,
    input  shadow_rd_t        rd,
    output logic [CODE_W-1:0] rd_data,
    output logic              busy
);

    logic [CODE_W-1:0]  shadow_mem [ENTRY_COUNT];
    logic [CODE_W-1:0]  rd_data_reg;
    logic [ENTRY_W-1:0] clr_cnt_reg;
    logic               busy_reg;

    logic               mem_we;
    logic [ENTRY_W-1:0] mem_waddr;
    logic [CODE_W-1:0]  mem_wdata;

    // Sweep every entry once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_cnt_reg == LAST_ENTRY)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + ENTRY_W'(1);
            end
        end
    end

    // Sweep owns the write port while busy
    always_comb
    begin
        mem_we    = busy_reg | wr.we;
        mem_waddr = busy_reg ? clr_cnt_reg : wr.addr;
        mem_wdata = busy_reg ? POISON_RESET : wr.data;
    end

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (rd.re)
        begin
            rd_data_reg <= shadow_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

    `SMAC_ASSERT(a_sweep_ends_at_last, clk, rst_n,
        $fell(busy_reg) |-> $past(clr_cnt_reg == LAST_ENTRY), "sweep ended early")
    `SMAC_ASSERT(a_sweep_once, clk, rst_n,
        !busy_reg |=> !busy_reg, "sweep restarted")
    `SMAC_ASSERT_NEVER(a_no_read_in_sweep, clk, rst_n,
        busy_reg && rd.re, "shadow read during sweep")

endmodule
